// File: sv/lss_pkg.sv
// lss_pkg: shared types and constants for the lifo stack with search
// opcodes, status codes, controller states and controller/datapath structs
// no dependencies
package lss_pkg;

  localparam int OPCODE_W = 3;
  localparam int OPERAND_W = 32;
  localparam int POP_W = 11;
  localparam int TOP_W = 32;
  localparam int INDEX_W = 11;
  localparam int OCC_W = 11;
  localparam int STATUS_W = 2;

  // found index when no entry matches (-1)
  localparam logic [INDEX_W-1:0] FOUND_NONE = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH      = 3'd0,
    OP_POP       = 3'd1,
    OP_OVERWRITE = 3'd2,
    OP_CLEAR     = 3'd3,
    OP_SEARCH    = 3'd4,
    OP_PEEK      = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PEEK,
    S_SEARCH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;       // input transfer: update count, write ram, latch key
    logic load_now;     // op resolved at accept: load its result
    logic load_peek;    // load top word from ram read data
    logic step;         // search walks one entry down
    logic load_search;  // search done: hit or miss from match flag
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_valid;    // result register holds an untaken result
    logic empty;        // stack holds no entry
    logic match;        // ram read data equals the search key
    logic at_bottom;    // search pointer is at entry 0
  } dp_stat_t;

endpackage

// File: sv/lss_if.sv
// lss_in_if / lss_out_if: valid/ready channels of the lifo stack
// depends on lss_pkg for field widths
interface lss_in_if;
  logic                                valid;
  logic                                ready;
  logic [lss_pkg::OPCODE_W-1:0]        opcode;
  logic signed [lss_pkg::OPERAND_W-1:0] operand_value;
  logic [lss_pkg::POP_W-1:0]           pop_count;

  modport source (output valid, opcode, operand_value, pop_count, input ready);
  modport sink (input valid, opcode, operand_value, pop_count, output ready);
endinterface

interface lss_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lss_pkg::TOP_W-1:0]   top_value;
  logic signed [lss_pkg::INDEX_W-1:0] found_index;
  logic [lss_pkg::OCC_W-1:0]          occupancy;
  logic [lss_pkg::STATUS_W-1:0]       status;

  modport source (output valid, top_value, found_index, occupancy, status, input ready);
  modport sink (input valid, top_value, found_index, occupancy, status, output ready);
endinterface

// File: sv/lss_ram.sv
// lss_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lss_ctrl.sv
// lss_ctrl: controller state machine of the lifo stack
// depends on lss_pkg (state_t, opcode_t, cmd_t, dp_stat_t)
module lss_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lss_pkg::OPCODE_W-1:0] opcode,
  input  logic                         out_ready,
  input  lss_pkg::dp_stat_t            stat,
  output lss_pkg::cmd_t                cmd
);

  lss_pkg::state_t state, state_next;
  logic free;

  // result register empty now or emptied at this edge
  assign free = !stat.out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lss_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    cmd = '0;
    case (state)
      lss_pkg::S_IDLE: begin
        in_ready = free;
        if (in_valid && free) begin
          cmd.accept = 1'b1;
          if (opcode == lss_pkg::OP_PEEK && !stat.empty) begin
            state_next = lss_pkg::S_PEEK;
          end else if (opcode == lss_pkg::OP_SEARCH && !stat.empty) begin
            state_next = lss_pkg::S_SEARCH;
          end else begin
            cmd.load_now = 1'b1;
          end
        end
      end
      lss_pkg::S_PEEK: begin
        cmd.load_peek = 1'b1;
        state_next = lss_pkg::S_IDLE;
      end
      lss_pkg::S_SEARCH: begin
        if (stat.match || stat.at_bottom) begin
          cmd.load_search = 1'b1;
          state_next = lss_pkg::S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = lss_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/lss_dp.sv
// lss_dp: datapath of the lifo stack: entry count, entry ram, search walk,
// result register; depends on lss_pkg and lss_ram
module lss_dp #(
  parameter int DEPTH = 1024,
  parameter int WORD_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [lss_pkg::OPCODE_W-1:0]         opcode,
  input  logic signed [lss_pkg::OPERAND_W-1:0] operand_value,
  input  logic [lss_pkg::POP_W-1:0]            pop_count,
  input  lss_pkg::cmd_t                        cmd,
  output lss_pkg::dp_stat_t                    stat,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [lss_pkg::TOP_W-1:0]     top_value,
  output logic signed [lss_pkg::INDEX_W-1:0]   found_index,
  output logic [lss_pkg::OCC_W-1:0]            occupancy,
  output logic [lss_pkg::STATUS_W-1:0]         status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > lss_pkg::POP_W) ? CW : lss_pkg::POP_W;

  logic [CW-1:0]         count, count_next;
  logic [AW-1:0]         cur;
  logic [WORD_WIDTH-1:0] key;

  logic [WORD_WIDTH-1:0] word;
  logic [WORD_WIDTH-1:0] rd_data;
  logic [AW-1:0]         top_addr, rd_addr, wr_addr;
  logic                  wr_en, empty, full;
  lss_pkg::status_t      res_status;

  // operand sign-extended or truncated to the stored word width
  assign word     = WORD_WIDTH'(operand_value);
  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));
  assign top_addr = AW'(count - CW'(1));
  assign rd_addr  = cmd.step ? (cur - AW'(1)) : top_addr;

  assign stat.out_valid = out_valid;
  assign stat.empty     = empty;
  assign stat.match     = (rd_data == key);
  assign stat.at_bottom = (cur == '0);

  // operations resolved at accept: count update, ram write and status
  always_comb begin
    count_next = count;
    wr_en = 1'b0;
    wr_addr = top_addr;
    res_status = lss_pkg::STAT_OK;
    case (opcode)
      lss_pkg::OP_PUSH: begin
        if (full) begin
          res_status = lss_pkg::STAT_FULL;
        end else begin
          wr_en = 1'b1;
          wr_addr = AW'(count);
          count_next = count + CW'(1);
        end
      end
      lss_pkg::OP_POP: begin
        if (PW'(pop_count) > PW'(count)) begin
          res_status = lss_pkg::STAT_UNDERFLOW;
        end else begin
          count_next = count - CW'(pop_count);
        end
      end
      lss_pkg::OP_OVERWRITE: begin
        if (empty) begin
          res_status = lss_pkg::STAT_EMPTY;
        end else begin
          wr_en = 1'b1;
        end
      end
      lss_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      lss_pkg::OP_PEEK: begin
        if (empty) begin
          res_status = lss_pkg::STAT_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  lss_ram #(
    .WIDTH(WORD_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en && cmd.accept),
    .waddr(wr_addr),
    .wdata(word),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key <= word;
      cur <= top_addr;
    end else if (cmd.step) begin
      cur <= cur - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.load_now || cmd.load_peek || cmd.load_search ||
                   (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_now) begin
      top_value   <= '0;
      found_index <= lss_pkg::FOUND_NONE;
      occupancy   <= lss_pkg::OCC_W'(count_next);
      status      <= res_status;
    end else if (cmd.load_peek) begin
      top_value   <= lss_pkg::TOP_W'($signed(rd_data));
      found_index <= lss_pkg::FOUND_NONE;
      occupancy   <= lss_pkg::OCC_W'(count);
      status      <= lss_pkg::STAT_OK;
    end else if (cmd.load_search) begin
      top_value   <= '0;
      found_index <= stat.match ? lss_pkg::INDEX_W'(cur) : lss_pkg::FOUND_NONE;
      occupancy   <= lss_pkg::OCC_W'(count);
      status      <= lss_pkg::STAT_OK;
    end
  end

endmodule

// File: sv/lifo_stack_with_search.sv
// lifo_stack_with_search: top level of the fixed-depth lifo stack with search
// depends on lss_pkg, lss_if, lss_ctrl, lss_dp (which holds lss_ram)
//
//   channel  dir  payload                                         transfer when
//   in_ch    in   opcode, operand_value, pop_count                 valid & ready
//   out_ch   out  top_value, found_index, occupancy, status        valid & ready
//
// push, pop, overwrite, clear and unknown opcodes: result registered at the
//   transfer edge, so one item per cycle while out_ch keeps taking results
// peek: one registered read of the entry ram in state S_PEEK, then the result loads
// search: one entry per cycle on the single ram read port, from the top entry
//   down, stopping at the first match
// rst (synchronous) empties the stack; the entry ram is not cleared
// a new item is taken while a finished result sits in the output register
//   only if out_ch takes that result in the same cycle
module lifo_stack_with_search #(
  parameter int DEPTH = 1024,
  parameter int WORD_WIDTH = 32
) (
  input logic           clk,
  input logic           rst,
  lss_in_if.sink        in_ch,
  lss_out_if.source     out_ch
);

  lss_pkg::cmd_t     cmd;
  lss_pkg::dp_stat_t stat;

  // controller: handshake, op dispatch, peek and search sequencing
  lss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .opcode   (in_ch.opcode),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: entry count, entry ram, search pointer and key, result register
  lss_dp #(
    .DEPTH     (DEPTH),
    .WORD_WIDTH(WORD_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .opcode       (in_ch.opcode),
    .operand_value(in_ch.operand_value),
    .pop_count    (in_ch.pop_count),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .top_value    (out_ch.top_value),
    .found_index  (out_ch.found_index),
    .occupancy    (out_ch.occupancy),
    .status       (out_ch.status)
  );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for the lifo stack with search
// depends on lss_pkg, lss_in_if / lss_out_if and lifo_stack_with_search

module tb_top;

  localparam int STACK_DEPTH = 1024;
  localparam int WORD_W = 32;
  localparam int CYCLE_LIMIT = 400000;   // watchdog limit on the run
  localparam int OUT_HOLD_CYCLES = 300;  // long receiver hold-off
  localparam int IDLE_PCT = 37;
  localparam int RANDOM_ITEMS = 150;
  localparam int DIR_ROWS = 25;
  localparam int SETTLE_CYCLES = 16;
  localparam int FILL_EXTRA = 3;         // pushes past full, all dropped
  localparam int HIGH_WATER = 60;        // random traffic keeps the stack around here

  // opcodes outside the defined set: no-ops with status ok
  localparam logic [lss_pkg::OPCODE_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [lss_pkg::OPCODE_W-1:0] OP_UNUSED_7 = 3'd7;

  // odd words fill the stack, so an even key is a guaranteed miss
  localparam logic signed [lss_pkg::OPERAND_W-1:0] EVEN_KEY = 32'sd2;

  typedef struct packed {
    logic [lss_pkg::OPCODE_W-1:0]         op;
    logic signed [lss_pkg::OPERAND_W-1:0] value;
    logic [lss_pkg::POP_W-1:0]            count;
  } stack_op_t;

  typedef struct packed {
    logic signed [lss_pkg::TOP_W-1:0] top;
    logic [lss_pkg::INDEX_W-1:0]      found;
    logic [lss_pkg::OCC_W-1:0]        occ;
    logic [lss_pkg::STATUS_W-1:0]     status;
  } stack_res_t;

  // directed row: operation, whether the result is typed in, typed result
  typedef struct packed {
    stack_op_t  cmd;
    logic       typed;
    stack_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  lss_in_if  in_ch ();
  lss_out_if out_ch ();

  lifo_stack_with_search #(
    .DEPTH      (STACK_DEPTH),
    .WORD_WIDTH (WORD_W)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow of the stack contents and depth, updated on every input transfer
  logic signed [WORD_W-1:0] stack_mem [STACK_DEPTH];
  int                       stack_depth;

  // results owed by the block, oldest first
  stack_res_t pending_results[$];
  int         mismatch_count = 0;

  // shared knobs between the sender and the receiver
  bit gaps_on = 1'b1;
  bit out_hold_req = 1'b0;

  // directed table: empty-stack cases, extremes of every field, every opcode,
  // topmost match, underflow with the largest count, clear
  dir_row_t dir_rows [DIR_ROWS] = '{
    // empty stack right after reset
    '{'{lss_pkg::OP_PEEK, 32'sd0, 11'd0}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd0, lss_pkg::STAT_EMPTY}},
    '{'{lss_pkg::OP_OVERWRITE, 32'sd5, 11'd0}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd0, lss_pkg::STAT_EMPTY}},
    '{'{lss_pkg::OP_SEARCH, 32'sd0, 11'd0}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd0, lss_pkg::STAT_OK}},
    '{'{lss_pkg::OP_POP, 32'sd0, 11'd1}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd0, lss_pkg::STAT_UNDERFLOW}},
    '{'{lss_pkg::OP_POP, 32'sd0, 11'd0}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd0, lss_pkg::STAT_OK}},
    // extremes of the word
    '{'{lss_pkg::OP_PUSH, 32'sh7FFFFFFF, 11'd0}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd1, lss_pkg::STAT_OK}},
    '{'{lss_pkg::OP_PUSH, 32'sh80000000, 11'd0}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd2, lss_pkg::STAT_OK}},
    '{'{lss_pkg::OP_PUSH, -32'sd1, 11'd0}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd3, lss_pkg::STAT_OK}},
    '{'{lss_pkg::OP_PUSH, 32'sd0, 11'd0}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd4, lss_pkg::STAT_OK}},
    '{'{lss_pkg::OP_PEEK, 32'sd0, 11'd0}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd4, lss_pkg::STAT_OK}},
    // search: bottom hit, middle hit, miss
    '{'{lss_pkg::OP_SEARCH, 32'sh7FFFFFFF, 11'd0}, 1'b1,
      '{32'sd0, 11'd0, 11'd4, lss_pkg::STAT_OK}},
    '{'{lss_pkg::OP_SEARCH, -32'sd1, 11'd0}, 1'b1,
      '{32'sd0, 11'd2, 11'd4, lss_pkg::STAT_OK}},
    '{'{lss_pkg::OP_SEARCH, 32'sh12345678, 11'd0}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd4, lss_pkg::STAT_OK}},
    // overwrite the top with a word already stored lower: topmost match wins
    '{'{lss_pkg::OP_OVERWRITE, 32'sh80000000, 11'd0}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd4, lss_pkg::STAT_OK}},
    '{'{lss_pkg::OP_SEARCH, 32'sh80000000, 11'd0}, 1'b0, '0},
    '{'{lss_pkg::OP_PEEK, 32'sd0, 11'd0}, 1'b1,
      '{32'sh80000000, lss_pkg::FOUND_NONE, 11'd4, lss_pkg::STAT_OK}},
    // undefined opcodes, one with the largest pop count, one with the most negative word
    '{'{OP_UNUSED_6, 32'sh2468ACE1, 11'h7FF}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd4, lss_pkg::STAT_OK}},
    '{'{OP_UNUSED_7, 32'sh80000000, 11'd0}, 1'b0, '0},
    // pop beyond occupancy, then a legal multi-pop
    '{'{lss_pkg::OP_POP, 32'sd0, 11'h7FF}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd4, lss_pkg::STAT_UNDERFLOW}},
    '{'{lss_pkg::OP_POP, 32'sd0, 11'd5}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd4, lss_pkg::STAT_UNDERFLOW}},
    '{'{lss_pkg::OP_POP, 32'sd0, 11'd2}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd2, lss_pkg::STAT_OK}},
    '{'{lss_pkg::OP_PEEK, 32'sd0, 11'd0}, 1'b1,
      '{32'sh80000000, lss_pkg::FOUND_NONE, 11'd2, lss_pkg::STAT_OK}},
    '{'{lss_pkg::OP_CLEAR, -32'sd1, 11'h7FF}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd0, lss_pkg::STAT_OK}},
    '{'{lss_pkg::OP_PUSH, 32'sh55555555, 11'd0}, 1'b1,
      '{32'sd0, lss_pkg::FOUND_NONE, 11'd1, lss_pkg::STAT_OK}},
    '{'{lss_pkg::OP_SEARCH, 32'sh55555555, 11'd0}, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // stack behavior: apply one operation to the shadow, return the result
  // ---------------------------------------------------------------------------
  function automatic stack_res_t stack_apply(input stack_op_t cmd);
    stack_res_t r;
    r.top = '0;
    r.found = lss_pkg::FOUND_NONE;
    r.status = lss_pkg::STAT_OK;
    case (cmd.op)
      lss_pkg::OP_PUSH: begin
        // full stack drops the word
        if (stack_depth >= STACK_DEPTH) begin
          r.status = lss_pkg::STAT_FULL;
        end else begin
          stack_mem[stack_depth] = cmd.value;
          stack_depth++;
        end
      end
      lss_pkg::OP_POP: begin
        // too many entries asked for: nothing moves
        if (int'(cmd.count) > stack_depth) r.status = lss_pkg::STAT_UNDERFLOW;
        else stack_depth -= int'(cmd.count);
      end
      lss_pkg::OP_OVERWRITE: begin
        if (stack_depth == 0) r.status = lss_pkg::STAT_EMPTY;
        else stack_mem[stack_depth-1] = cmd.value;
      end
      lss_pkg::OP_CLEAR: begin
        stack_depth = 0;
      end
      lss_pkg::OP_SEARCH: begin
        // walk from the top down, first match is the topmost one
        for (int i = stack_depth - 1; i >= 0; i--) begin
          if (stack_mem[i] == cmd.value) begin
            r.found = lss_pkg::INDEX_W'(i);
            break;
          end
        end
      end
      lss_pkg::OP_PEEK: begin
        if (stack_depth == 0) r.status = lss_pkg::STAT_EMPTY;
        else r.top = stack_mem[stack_depth-1];
      end
      default: begin
        // undefined opcodes change nothing
      end
    endcase
    r.occ = lss_pkg::OCC_W'(stack_depth);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // random stimulus
  // ---------------------------------------------------------------------------

  // words: small values collide often, extremes hit the sign bit, rest is raw
  function automatic logic signed [lss_pkg::OPERAND_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return lss_pkg::OPERAND_W'($signed($urandom_range(0, 7)) - 4);
    if (r < 5) return r[0] ? 32'sh7FFFFFFF : 32'sh80000000;
    return $urandom;
  endfunction

  // search keys: half of them words that are on the stack, so hits are common
  function automatic logic signed [lss_pkg::OPERAND_W-1:0] pick_key();
    if (stack_depth > 0 && $urandom_range(0, 9) < 5)
      return stack_mem[$urandom_range(0, stack_depth - 1)];
    return pick_word();
  endfunction

  function automatic stack_op_t gen_random_op();
    stack_op_t c;
    int        r;
    int        push_cut;
    int        q;
    c.value = pick_word();
    c.count = lss_pkg::POP_W'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    // fewer pushes once the stack is deep, so searches stay short
    push_cut = (stack_depth > HIGH_WATER) ? 22 : 45;
    if (r < 3) begin
      c.op = r[0] ? OP_UNUSED_6 : OP_UNUSED_7;
      c.count = lss_pkg::POP_W'($urandom_range(0, (1 << lss_pkg::POP_W) - 1));
    end else if (r < 6) begin
      c.op = lss_pkg::OP_CLEAR;
    end else if (r < push_cut) begin
      c.op = lss_pkg::OP_PUSH;
    end else if (r < push_cut + 14) begin
      c.op = lss_pkg::OP_POP;
      q = $urandom_range(0, 9);
      // small pops, pops around the current depth, and any count at all
      if (q >= 6 && q < 9) begin
        c.count = lss_pkg::POP_W'($urandom_range(0, stack_depth + 2));
      end else if (q == 9) begin
        c.count = lss_pkg::POP_W'($urandom_range(0, (1 << lss_pkg::POP_W) - 1));
      end
    end else if (r < push_cut + 24) begin
      c.op = lss_pkg::OP_OVERWRITE;
    end else if (r < push_cut + 40) begin
      c.op = lss_pkg::OP_SEARCH;
      c.value = pick_key();
    end else begin
      c.op = lss_pkg::OP_PEEK;
    end
    return c;
  endfunction

  function automatic stack_op_t make_op(input logic [lss_pkg::OPCODE_W-1:0] op,
                                        input logic signed [lss_pkg::OPERAND_W-1:0] value,
                                        input int count);
    stack_op_t c;
    c.op = op;
    c.value = value;
    c.count = lss_pkg::POP_W'(count);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one transfer per call, random idle cycles before it
  // ---------------------------------------------------------------------------
  task automatic send_op(input stack_op_t cmd, input logic typed, input stack_res_t typed_res);
    stack_res_t predicted;
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= cmd.op;
    in_ch.operand_value <= cmd.value;
    in_ch.pop_count     <= cmd.count;
    do @(posedge clk); while (!in_ch.ready);
    // transfer done: update the shadow and queue what the block owes
    predicted = stack_apply(cmd);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // sender pause: drop valid and wait for every owed result
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic note_mismatch(input string field, input longint exp_v, input longint got_v);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d got %0d", $time, field, exp_v, got_v);
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // output side: ready with random idling, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_hold_req) begin
        // hold off while the sender keeps offering, so the block backs up
        out_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (OUT_HOLD_CYCLES - 1) @(negedge clk);
      end else if (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every output transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    stack_res_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, occupancy %0d status %0d", $time,
                 out_ch.occupancy, out_ch.status);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.top_value !== exp_r.top)
          note_mismatch("top_value", exp_r.top, out_ch.top_value);
        if (out_ch.found_index !== exp_r.found)
          note_mismatch("found_index", $signed(exp_r.found), out_ch.found_index);
        if (out_ch.occupancy !== exp_r.occ)
          note_mismatch("occupancy", exp_r.occ, out_ch.occupancy);
        if (out_ch.status !== exp_r.status)
          note_mismatch("status", exp_r.status, out_ch.status);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = '0;
    in_ch.operand_value = '0;
    in_ch.pop_count     = '0;
    stack_depth         = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int n = 0; n < DIR_ROWS; n++)
      send_op(dir_rows[n].cmd, dir_rows[n].typed, dir_rows[n].res);

    // fill to the top: sender waits for the block to drain first
    wait_for_results();
    send_op(make_op(lss_pkg::OP_CLEAR, pick_word(), 0), 1'b0, '0);
    for (int k = 0; k < STACK_DEPTH + FILL_EXTRA; k++) begin
      // the receiver stalls once while the stack is half full
      if (k == STACK_DEPTH / 2) out_hold_req = 1'b1;
      send_op(make_op(lss_pkg::OP_PUSH, pick_word() | 32'sd1, 0), 1'b0, '0);
    end
    // full stack: peek, overwrite, hit at the top index, full-length miss,
    // search for the bottom word, underflow by one, then pop everything
    send_op(make_op(lss_pkg::OP_PEEK, 32'sd0, 0), 1'b0, '0);
    send_op(make_op(lss_pkg::OP_OVERWRITE, 32'sh7FFFFFFF, 0), 1'b0, '0);
    send_op(make_op(lss_pkg::OP_SEARCH, 32'sh7FFFFFFF, 0), 1'b0, '0);
    send_op(make_op(lss_pkg::OP_SEARCH, EVEN_KEY, 0), 1'b0, '0);
    send_op(make_op(lss_pkg::OP_SEARCH, stack_mem[0], 0), 1'b0, '0);
    send_op(make_op(lss_pkg::OP_POP, 32'sd0, STACK_DEPTH + 1), 1'b0, '0);
    send_op(make_op(lss_pkg::OP_POP, 32'sd0, STACK_DEPTH), 1'b0, '0);

    // random traffic, with a long no-idle stretch in the middle
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 30) out_hold_req = 1'b1;
      if (n == 100) wait_for_results();
      gaps_on = !(n >= 50 && n < 120);
      send_op(gen_random_op(), 1'b0, '0);
    end

    // wind down: every result taken, then a few quiet cycles
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: lifo_stack_with_search.f
sv/lss_pkg.sv
sv/lss_if.sv
sv/lss_ram.sv
sv/lss_ctrl.sv
sv/lss_dp.sv
sv/lifo_stack_with_search.sv
tb/sv/tb_top.sv
